// ===== rtl/core/fsac_pkg.sv =====
// Package for the free slot allocator: payload and queue types, result and
// operation codes, and the count tree rebuild helpers.
// No dependencies.
`default_nettype none

package fsac_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic FUNC_TAKE   = 1'b0;
  localparam logic FUNC_RETURN = 1'b1;

  localparam logic [1:0] ST_GRANTED   = 2'd0;
  localparam logic [1:0] ST_NONE_FREE = 2'd1;
  localparam logic [1:0] ST_RETURNED  = 2'd2;
  localparam logic [1:0] ST_REJECTED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TAKEN  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic [1:0]        status;
    logic [CNT_W-1:0]  free_count;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_TAKE   = 2'd0,
    OP_RETURN = 2'd1,
    OP_REJECT = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
  } qent_t;

  typedef struct packed {
    logic [CNT_W-1:0]  slots_in_use;
    logic              start_taken;
    logic [SLOT_W-1:0] top_step;
  } cfg_t;

  typedef struct packed {
    logic             mark;
    logic [CNT_W-1:0] cnt;
  } node_t;

  function automatic logic [CNT_W-1:0] clamp_slots(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_W'(MAX_SLOTS)) begin
      r = CNT_W'(MAX_SLOTS);
    end
    return r;
  endfunction

  // highest power of two below n, zero for a single slot
  function automatic logic [SLOT_W-1:0] top_step_of(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] m;
    logic [CNT_W-1:0] t;
    m = n - CNT_W'(1);
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    t = m ^ (m >> 1);
    return t[SLOT_W-1:0];
  endfunction

  // node idx covers slots idx .. idx + lowbit(idx) - 1; node 0 covers all
  function automatic node_t build_node(input logic [SLOT_W-1:0] idx, input cfg_t cfg);
    node_t            nd;
    logic [SLOT_W-1:0] lb;
    logic [CNT_W-1:0]  hi;
    logic [CNT_W-1:0]  lim;
    lb  = idx & (~idx + SLOT_W'(1));
    hi  = {1'b0, idx} + {1'b0, lb};
    lim = (hi < cfg.slots_in_use) ? hi : cfg.slots_in_use;
    nd  = '0;
    if (!cfg.start_taken && ({1'b0, idx} < cfg.slots_in_use)) begin
      nd.mark = 1'b1;
      nd.cnt  = (idx == '0) ? cfg.slots_in_use : (lim - {1'b0, idx});
    end
    return nd;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fsac_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module fsac_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsac_front.sv =====
// Request front end: takes items and classifies them as take, return or
// reject before queueing. Depends on fsac_pkg.
`default_nettype none

module fsac_front (
  input  logic                 building,
  input  fsac_pkg::cfg_t       cfg,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  fsac_pkg::req_t       req,
  output logic                 push_valid,
  input  logic                 push_ready,
  output fsac_pkg::qent_t      push_data
);

  logic in_range;

  assign in_range   = {1'b0, req.slot} < cfg.slots_in_use;
  assign req_ready  = push_ready && !building;
  assign push_valid = req_valid && !building;

  always_comb begin
    push_data.slot = req.slot;
    if (req.func == fsac_pkg::FUNC_TAKE) begin
      push_data.op = fsac_pkg::OP_TAKE;
    end else if (in_range) begin
      push_data.op = fsac_pkg::OP_RETURN;
    end else begin
      push_data.op = fsac_pkg::OP_REJECT;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsac_queue.sv =====
// Small FIFO of classified items between front end and tree engine.
// Depends on fsac_pkg.
`default_nettype none

module fsac_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  fsac_pkg::qent_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fsac_pkg::qent_t pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fsac_pkg::qent_t  entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsac_back.sv =====
// Tree engine: count tree RAM, rebuild sweep, take descent, return path
// update and the result register. Depends on fsac_pkg and fsac_ram.
`default_nettype none

module fsac_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            rebuild,
  input  fsac_pkg::cfg_t  cfg,
  output logic            building,
  input  logic            q_valid,
  output logic            q_ready,
  input  fsac_pkg::qent_t q_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output fsac_pkg::rsp_t  rsp
);

  localparam int unsigned SW = fsac_pkg::SLOT_W;
  localparam int unsigned CW = fsac_pkg::CNT_W;
  localparam int unsigned NW = $bits(fsac_pkg::node_t);

  typedef enum logic [4:0] {
    S_BUILD = 5'b00001,
    S_IDLE  = 5'b00010,
    S_TAKE0 = 5'b00100,
    S_DESC  = 5'b01000,
    S_RET   = 5'b10000
  } state_t;

  state_t          state, state_next;
  logic [SW-1:0]   build_idx, build_idx_next;
  logic [SW-1:0]   pos, pos_next;
  logic [SW-1:0]   step, step_next;
  logic [SW-1:0]   child, child_next;
  logic [SW-1:0]   cur, cur_next;
  logic [CW-1:0]   last_dec, last_dec_next;
  logic            first, first_next;
  logic [CW-1:0]   total, total_next;

  logic            ram_we;
  logic [SW-1:0]   ram_waddr;
  fsac_pkg::node_t ram_wdata;
  logic [SW-1:0]   ram_raddr;
  logic [NW-1:0]   ram_rdata;
  fsac_pkg::node_t rd;

  logic            emit;
  fsac_pkg::rsp_t  emit_data;

  logic            mv;
  logic [SW-1:0]   npos;
  logic [SW-1:0]   nstep;
  logic [CW-1:0]   ndec;
  logic [SW-1:0]   nxt;

  fsac_ram #(
    .WIDTH (NW),
    .DEPTH (fsac_pkg::MAX_SLOTS)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd       = fsac_pkg::node_t'(ram_rdata);
  assign building = state == S_BUILD;
  assign mv       = ({1'b0, child} < cfg.slots_in_use) && (rd.cnt != '0);
  assign npos     = mv ? child : pos;
  assign nstep    = step >> 1;
  assign ndec     = mv ? (rd.cnt - CW'(1)) : last_dec;
  assign nxt      = cur & (cur - SW'(1));

  always_comb begin
    state_next     = state;
    build_idx_next = build_idx;
    pos_next       = pos;
    step_next      = step;
    child_next     = child;
    cur_next       = cur;
    last_dec_next  = last_dec;
    first_next     = first;
    total_next     = total;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    emit           = 1'b0;
    emit_data      = '0;
    q_ready        = 1'b0;

    case (state)
      S_BUILD: begin
        ram_we         = 1'b1;
        ram_waddr      = build_idx;
        ram_wdata      = fsac_pkg::build_node(build_idx, cfg);
        build_idx_next = build_idx + SW'(1);
        if (build_idx == '0) begin
          total_next = cfg.start_taken ? '0 : cfg.slots_in_use;
        end
        if (build_idx == SW'(fsac_pkg::MAX_SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && (!rsp_valid || rsp_ready)) begin
          q_ready = 1'b1;
          case (q_data.op)
            fsac_pkg::OP_TAKE: begin
              if (total == '0) begin
                emit                 = 1'b1;
                emit_data.status     = fsac_pkg::ST_NONE_FREE;
                emit_data.free_count = total;
              end else begin
                ram_raddr  = '0;
                state_next = S_TAKE0;
              end
            end
            fsac_pkg::OP_RETURN: begin
              ram_raddr  = q_data.slot;
              cur_next   = q_data.slot;
              first_next = 1'b1;
              state_next = S_RET;
            end
            default: begin
              emit                 = 1'b1;
              emit_data.status     = fsac_pkg::ST_REJECTED;
              emit_data.free_count = total;
            end
          endcase
        end
      end
      S_TAKE0: begin
        ram_we        = 1'b1;
        ram_waddr     = '0;
        ram_wdata.cnt = rd.cnt - CW'(1);
        if (cfg.top_step == '0) begin
          ram_wdata.mark       = 1'b0;
          emit                 = 1'b1;
          emit_data.status     = fsac_pkg::ST_GRANTED;
          emit_data.free_count = total - CW'(1);
          total_next           = total - CW'(1);
          state_next           = S_IDLE;
        end else begin
          ram_wdata.mark = rd.mark;
          last_dec_next  = rd.cnt - CW'(1);
          pos_next       = '0;
          step_next      = cfg.top_step;
          child_next     = cfg.top_step;
          ram_raddr      = cfg.top_step;
          state_next     = S_DESC;
        end
      end
      S_DESC: begin
        ram_we         = mv || (nstep == '0);
        ram_waddr      = npos;
        ram_wdata.mark = (nstep != '0) && rd.mark;
        ram_wdata.cnt  = ndec;
        if (nstep == '0) begin
          emit                   = 1'b1;
          emit_data.granted_slot = npos;
          emit_data.status       = fsac_pkg::ST_GRANTED;
          emit_data.free_count   = total - CW'(1);
          total_next             = total - CW'(1);
          state_next             = S_IDLE;
        end else begin
          pos_next      = npos;
          step_next     = nstep;
          last_dec_next = ndec;
          child_next    = npos | nstep;
          ram_raddr     = npos | nstep;
        end
      end
      S_RET: begin
        if (first && rd.mark) begin
          emit                 = 1'b1;
          emit_data.status     = fsac_pkg::ST_REJECTED;
          emit_data.free_count = total;
          state_next           = S_IDLE;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = cur;
          ram_wdata.mark = first || rd.mark;
          ram_wdata.cnt  = rd.cnt + CW'(1);
          if (cur == '0) begin
            emit                 = 1'b1;
            emit_data.status     = fsac_pkg::ST_RETURNED;
            emit_data.free_count = total + CW'(1);
            total_next           = total + CW'(1);
            state_next           = S_IDLE;
          end else begin
            ram_raddr  = nxt;
            cur_next   = nxt;
            first_next = 1'b0;
          end
        end
      end
      default: begin
        state_next     = S_BUILD;
        build_idx_next = '0;
      end
    endcase

    if (rebuild) begin
      state_next     = S_BUILD;
      build_idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BUILD;
      build_idx <= '0;
      total     <= '0;
      first     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      build_idx <= build_idx_next;
      total     <= total_next;
      first     <= first_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    step     <= step_next;
    child    <= child_next;
    cur      <= cur_next;
    last_dec <= last_dec_next;
    if (emit) begin
      rsp <= emit_data;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_BUILD) |-> (total <= cfg.slots_in_use))
    else $error("free total exceeds managed slot count");

  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_DESC) |-> $onehot(step))
    else $error("descent step is not a single bit");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!rsp_valid || rsp_ready))
    else $error("result produced while result register is occupied");

  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == fsac_pkg::ST_GRANTED))
      |-> ({1'b0, rsp.granted_slot} < cfg.slots_in_use))
    else $error("granted slot outside managed range");

endmodule

`default_nettype wire

// ===== rtl/core/free_slot_allocator_count_tree.sv =====
// Top level of the free slot allocator: configuration registers, front end,
// item queue and tree engine. Depends on fsac_pkg, fsac_front, fsac_queue,
// fsac_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   req     | in        | req_valid/req_ready  | func, slot
//   rsp     | out       | rsp_valid/rsp_ready  | granted_slot, status, free_count
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A take reads the root and then descends the tree, one RAM read per tree level.
// A return walks the ancestor path of its slot up to the root, updating each node.
// Empty takes and out-of-range returns are answered from idle without a tree walk.
// After reset and after every configuration write the engine sweeps all 1024
// tree entries, one per cycle; req_ready stays low while the sweep runs.
// The queue holds up to QUEUE_DEPTH items while the engine works or rsp stalls.
`default_nettype none

module free_slot_allocator_count_tree #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  fsac_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output fsac_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fsac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsac_pkg::CNT_W-1:0]          cfg_data
);

  fsac_pkg::cfg_t             cfg;
  logic [fsac_pkg::CNT_W-1:0] clamped;
  logic                       building;
  logic                       push_valid;
  logic                       push_ready;
  fsac_pkg::qent_t            push_data;
  logic                       pop_valid;
  logic                       pop_ready;
  fsac_pkg::qent_t            pop_data;

  assign cfg_ready = 1'b1;
  assign clamped   = fsac_pkg::clamp_slots(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slots_in_use <= fsac_pkg::CNT_W'(fsac_pkg::MAX_SLOTS);
      cfg.start_taken  <= 1'b0;
      cfg.top_step     <= fsac_pkg::top_step_of(fsac_pkg::CNT_W'(fsac_pkg::MAX_SLOTS));
    end else if (cfg_valid) begin
      case (cfg_index)
        fsac_pkg::CFG_SLOTS_IN_USE: begin
          cfg.slots_in_use <= clamped;
          cfg.top_step     <= fsac_pkg::top_step_of(clamped);
        end
        fsac_pkg::CFG_START_TAKEN: begin
          cfg.start_taken <= cfg_data[0];
        end
        default: begin
          cfg.start_taken <= cfg.start_taken;
        end
      endcase
    end
  end

  fsac_front u_front (
    .building   (building),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fsac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fsac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rebuild   (cfg_valid),
    .cfg       (cfg),
    .building  (building),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
